[rtl/dgat_pkg.sv]
// dgat_pkg: shared types, constants and helper functions of the goto angle transmitter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package dgat_pkg;

  // frame layout
  localparam int unsigned FrameBits = 45;
  localparam int unsigned BitsW     = 6;
  localparam int unsigned TickW     = 12;
  localparam int unsigned CycW      = 6;

  localparam logic [7:0] FramingByte = 8'hE0;
  localparam logic [7:0] AddressByte = 8'h31;
  localparam logic [7:0] GotoCmdByte = 8'h6E;
  localparam logic [3:0] EastNibble  = 4'hE;
  localparam logic [3:0] WestNibble  = 4'hD;

  // configuration register reset values
  localparam logic [7:0]  HighTimeRst   = 8'd16;
  localparam logic [7:0]  LowTimeRst    = 8'd17;
  localparam logic [5:0]  LongBurstRst  = 6'd22;
  localparam logic [5:0]  ShortBurstRst = 6'd11;
  localparam logic [11:0] LongGapRst    = 12'd1000;
  localparam logic [11:0] ShortGapRst   = 12'd500;
  localparam logic [11:0] AngleLimitRst = 12'd1200;

  localparam int unsigned AddrW = 5;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_HIGH_TIME   = 3'd0,
    REG_LOW_TIME    = 3'd1,
    REG_LONG_BURST  = 3'd2,
    REG_SHORT_BURST = 3'd3,
    REG_LONG_GAP    = 3'd4,
    REG_SHORT_GAP   = 3'd5,
    REG_ANGLE_LIMIT = 3'd6
  } reg_idx_e;

  // request kinds
  localparam logic ReqTick = 1'b0;
  localparam logic ReqGoto = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] angle;
  } in_item_t;

  typedef struct packed {
    logic line;
    logic busy_res;
    logic accepted;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  high_time;
    logic [7:0]  low_time;
    logic [5:0]  long_burst_cycles;
    logic [5:0]  short_burst_cycles;
    logic [11:0] long_gap;
    logic [11:0] short_gap;
    logic [11:0] angle_limit;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic line;
  } core_status_t;

  // zero counts behave as one
  function automatic logic [7:0] at_least_one8(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic logic [5:0] at_least_one6(input logic [5:0] v);
    return (v == 6'd0) ? 6'd1 : v;
  endfunction

  // byte followed by its odd parity bit
  function automatic logic [8:0] with_parity(input logic [7:0] b);
    return {b, ~(^b)};
  endfunction

endpackage

[rtl/diseqc_goto_angle_transmitter.sv]
// diseqc_goto_angle_transmitter: top level of the goto angle tone transmitter
// results: each accepted transaction's result is registered in the result buffer and offered from there
// throughput: one transaction per cycle, set by the single-pass step logic of the
//   frame core and the two-entry result buffer, which stalls input only when full
// reset: asynchronous, configuration registers return to their defaults and the line goes idle low
// depends on dgat_pkg, dgat_cfg_regs, dgat_frame_core, dgat_out_buf
`timescale 1ns / 1ps

module diseqc_goto_angle_transmitter
  import dgat_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t         cfg;
  out_item_t    core_res;
  core_status_t status;
  logic         buf_full;
  logic         accept;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  // configuration registers
  dgat_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // frame and tone sequencer
  dgat_frame_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept),
    .item_i   (in_data_i),
    .cfg_i    (cfg),
    .res_o    (core_res),
    .status_o (status)
  );

  // result buffer
  dgat_out_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (core_res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // checks
  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.accepted |-> out_data_o.busy_res)
    else $error("accepted goto reported as not busy");

  a_idle_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !status.busy |-> !status.line)
    else $error("line high while no frame is in progress");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  a_goto_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_data_i.req_type == ReqGoto) && !status.busy |=> status.busy && status.line)
    else $error("goto on idle core did not start a frame");

endmodule

[rtl/dgat_cfg_regs.sv]
// dgat_cfg_regs: configuration registers behind an apb-style port
// depends on dgat_pkg
`timescale 1ns / 1ps

module dgat_cfg_regs
  import dgat_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_o  = cfg_q;

  // write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_HIGH_TIME:   cfg_d.high_time          = pwdata[7:0];
        REG_LOW_TIME:    cfg_d.low_time           = pwdata[7:0];
        REG_LONG_BURST:  cfg_d.long_burst_cycles  = pwdata[5:0];
        REG_SHORT_BURST: cfg_d.short_burst_cycles = pwdata[5:0];
        REG_LONG_GAP:    cfg_d.long_gap           = pwdata[11:0];
        REG_SHORT_GAP:   cfg_d.short_gap          = pwdata[11:0];
        REG_ANGLE_LIMIT: cfg_d.angle_limit        = pwdata[11:0];
        default:         cfg_d                    = cfg_q;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_HIGH_TIME:   prdata = {24'd0, cfg_q.high_time};
      REG_LOW_TIME:    prdata = {24'd0, cfg_q.low_time};
      REG_LONG_BURST:  prdata = {26'd0, cfg_q.long_burst_cycles};
      REG_SHORT_BURST: prdata = {26'd0, cfg_q.short_burst_cycles};
      REG_LONG_GAP:    prdata = {20'd0, cfg_q.long_gap};
      REG_SHORT_GAP:   prdata = {20'd0, cfg_q.short_gap};
      REG_ANGLE_LIMIT: prdata = {20'd0, cfg_q.angle_limit};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_time          <= HighTimeRst;
      cfg_q.low_time           <= LowTimeRst;
      cfg_q.long_burst_cycles  <= LongBurstRst;
      cfg_q.short_burst_cycles <= ShortBurstRst;
      cfg_q.long_gap           <= LongGapRst;
      cfg_q.short_gap          <= ShortGapRst;
      cfg_q.angle_limit        <= AngleLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/dgat_frame_core.sv]
// dgat_frame_core: frame builder and bit/tone sequencer, one step per transaction
// depends on dgat_pkg
`timescale 1ns / 1ps

module dgat_frame_core
  import dgat_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  in_item_t     item_i,
  input  cfg_t         cfg_i,
  output out_item_t    res_o,
  output core_status_t status_o
);

  logic [FrameBits-1:0] frame_q, frame_d;
  logic [BitsW-1:0]     bits_q, bits_d;
  logic                 in_gap_q, in_gap_d;
  logic [CycW-1:0]      cycles_q, cycles_d;
  logic [TickW-1:0]     tick_q, tick_d;
  logic                 line_q, line_d;

  logic                 neg;
  logic [16:0]          mag_full;
  logic [TickW-1:0]     mag;
  logic [7:0]           d1, d2;
  logic [FrameBits-1:0] new_frame;
  logic [TickW-1:0]     high_ticks, low_ticks;
  logic [TickW-1:0]     gap_ticks;
  logic [CycW-1:0]      next_cycles;
  logic                 do_next;

  assign status_o.busy = (bits_q != '0);
  assign status_o.line = line_q;

  // angle clamp and frame assembly
  always_comb begin
    neg      = item_i.angle[15];
    mag_full = neg ? (17'h10000 - {1'b0, item_i.angle}) : {1'b0, item_i.angle};
    mag      = (mag_full > {5'd0, cfg_i.angle_limit}) ? cfg_i.angle_limit
                                                      : mag_full[TickW-1:0];
    d1        = {(neg ? EastNibble : WestNibble), mag[11:8]};
    d2        = mag[7:0];
    new_frame = {with_parity(FramingByte), with_parity(AddressByte),
                 with_parity(GotoCmdByte), with_parity(d1), with_parity(d2)};
  end

  // phase lengths
  assign high_ticks  = {4'd0, at_least_one8(cfg_i.high_time)};
  assign low_ticks   = {4'd0, at_least_one8(cfg_i.low_time)};
  assign gap_ticks   = frame_q[FrameBits-1] ? cfg_i.long_gap : cfg_i.short_gap;
  // burst length of the bit after the current one
  assign next_cycles = at_least_one6(frame_q[FrameBits-2] ? cfg_i.short_burst_cycles
                                                          : cfg_i.long_burst_cycles);

  // step logic
  always_comb begin
    frame_d  = frame_q;
    bits_d   = bits_q;
    in_gap_d = in_gap_q;
    cycles_d = cycles_q;
    tick_d   = tick_q;
    line_d   = line_q;
    do_next  = 1'b0;
    res_o.line     = line_q;
    res_o.busy_res = (bits_q != '0);
    res_o.accepted = 1'b0;
    if (step_i) begin
      if (item_i.req_type == ReqGoto) begin
        if (bits_q == '0) begin
          frame_d  = new_frame;
          bits_d   = BitsW'(FrameBits);
          in_gap_d = 1'b0;
          cycles_d = at_least_one6(new_frame[FrameBits-1] ? cfg_i.short_burst_cycles
                                                          : cfg_i.long_burst_cycles);
          line_d   = 1'b1;
          tick_d   = high_ticks;
          res_o.line     = 1'b1;
          res_o.busy_res = 1'b1;
          res_o.accepted = 1'b1;
        end
      end else if (bits_q != '0) begin
        priority if (tick_q > TickW'(1)) begin
          tick_d = tick_q - TickW'(1);
        end else if (in_gap_q) begin
          do_next = 1'b1;
        end else if (line_q) begin
          line_d = 1'b0;
          tick_d = low_ticks;
        end else if (cycles_q > CycW'(1)) begin
          cycles_d = cycles_q - CycW'(1);
          line_d   = 1'b1;
          tick_d   = high_ticks;
        end else begin
          cycles_d = '0;
          if (gap_ticks == '0) begin
            do_next = 1'b1;
          end else begin
            in_gap_d = 1'b1;
            line_d   = 1'b0;
            tick_d   = gap_ticks;
          end
        end
        // move on to the next frame bit
        if (do_next) begin
          frame_d = {frame_q[FrameBits-2:0], 1'b0};
          bits_d  = bits_q - BitsW'(1);
          in_gap_d = 1'b0;
          if (bits_q == BitsW'(1)) begin
            cycles_d = '0;
            tick_d   = '0;
            line_d   = 1'b0;
          end else begin
            cycles_d = next_cycles;
            line_d   = 1'b1;
            tick_d   = high_ticks;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q  <= '0;
      bits_q   <= '0;
      in_gap_q <= 1'b0;
      cycles_q <= '0;
      tick_q   <= '0;
      line_q   <= 1'b0;
    end else begin
      frame_q  <= frame_d;
      bits_q   <= bits_d;
      in_gap_q <= in_gap_d;
      cycles_q <= cycles_d;
      tick_q   <= tick_d;
      line_q   <= line_d;
    end
  end

endmodule

[rtl/dgat_out_buf.sv]
// dgat_out_buf: two-entry result buffer between the core and the output channel
// depends on dgat_pkg
`timescale 1ns / 1ps

module dgat_out_buf
  import dgat_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t data_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  out_item_t  ent0_q, ent0_d, ent1_q, ent1_d;
  logic [1:0] count_q, count_d;
  logic       pop;
  logic [1:0] wr_pos;

  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign out_data_o  = ent0_q;
  assign pop         = out_valid_o && !out_stall_i;
  assign wr_pos      = count_q - {1'b0, pop};

  // shift on pop, write behind the last live entry on push
  always_comb begin
    ent0_d = pop ? ent1_q : ent0_q;
    ent1_d = ent1_q;
    if (push_i) begin
      if (wr_pos == 2'd0) begin
        ent0_d = data_i;
      end else begin
        ent1_d = data_i;
      end
    end
    count_d = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    ent0_q <= ent0_d;
    ent1_q <= ent1_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

[dv/tb_diseqc_goto_angle_transmitter.sv]
// tb_diseqc_goto_angle_transmitter: self-checking testbench for the goto angle tone transmitter
// drives goto and tick transactions, predicts every line result and checks it field by field
// depends on dgat_pkg and diseqc_goto_angle_transmitter
`timescale 1ns / 1ps

module tb_diseqc_goto_angle_transmitter;
  import dgat_pkg::*;

  localparam int unsigned QuietLimit = 2000;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_item_t         in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_item_t        out_data_o;
  logic             psel        = 1'b0;
  logic             penable     = 1'b0;
  logic             pwrite      = 1'b0;
  logic [AddrW-1:0] paddr       = '0;
  logic [31:0]      pwdata      = '0;
  logic [31:0]      prdata;
  logic             pready;

  // stimulus and expected line results
  in_item_t    items_to_send[$];
  out_item_t   line_results_due[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned gap_left       = 0;
  int unsigned hold_left      = 0;
  int unsigned rx_pause;
  bit          send_calm      = 1'b0;
  bit          recv_calm      = 1'b0;
  out_item_t   want;

  // shadow timing settings
  logic [7:0]  tone_high, tone_low;
  logic [5:0]  zero_burst, one_burst;
  logic [11:0] gap_after_one, gap_after_zero, angle_cap;

  // shadow frame state
  logic [44:0] frame_q;
  logic [5:0]  bits_rem;
  logic        in_silence;
  logic [5:0]  cyc_rem;
  logic [11:0] ticks_rem;
  logic        line_lvl;

  diseqc_goto_angle_transmitter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic log_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic int unsigned pause_for(input bit calm);
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  // ---------------- line predictor ----------------

  function automatic logic [11:0] no_zero(input logic [11:0] v);
    return (v == 12'd0) ? 12'd1 : v;
  endfunction

  // byte plus odd parity bit
  function automatic logic [8:0] parity_byte(input logic [7:0] b);
    return {b, 1'(($countones(b) % 2) == 0)};
  endfunction

  function automatic void start_bit();
    if (bits_rem == 6'd0) begin
      in_silence = 1'b0;
      cyc_rem    = 6'd0;
      ticks_rem  = 12'd0;
      line_lvl   = 1'b0;
    end else begin
      in_silence = 1'b0;
      cyc_rem    = 6'(no_zero(12'(frame_q[44] ? one_burst : zero_burst)));
      line_lvl   = 1'b1;
      ticks_rem  = no_zero(12'(tone_high));
    end
  endfunction

  function automatic void shift_to_next_bit();
    frame_q  = frame_q << 1;
    bits_rem = bits_rem - 6'd1;
    start_bit();
  endfunction

  // a zero gap moves straight on to the next bit
  function automatic void start_silence();
    logic [11:0] g;
    g = frame_q[44] ? gap_after_one : gap_after_zero;
    if (g == 12'd0) begin
      shift_to_next_bit();
    end else begin
      in_silence = 1'b1;
      line_lvl   = 1'b0;
      ticks_rem  = g;
    end
  endfunction

  function automatic void advance_one_tick();
    if (ticks_rem > 12'd1) begin
      ticks_rem = ticks_rem - 12'd1;
    end else if (in_silence) begin
      shift_to_next_bit();
    end else if (line_lvl) begin
      line_lvl  = 1'b0;
      ticks_rem = no_zero(12'(tone_low));
    end else if (cyc_rem > 6'd1) begin
      cyc_rem   = cyc_rem - 6'd1;
      line_lvl  = 1'b1;
      ticks_rem = no_zero(12'(tone_high));
    end else begin
      cyc_rem = 6'd0;
      start_silence();
    end
  endfunction

  function automatic out_item_t compute_line_result(input in_item_t it);
    out_item_t   r;
    logic        neg;
    logic [16:0] mag;
    logic [7:0]  hdr;
    r = '0;
    // goto taken only when no frame is in flight
    if (it.req_type == ReqGoto && bits_rem == 6'd0) begin
      neg = it.angle[15];
      mag = neg ? (17'h10000 - {1'b0, it.angle}) : {1'b0, it.angle};
      if (mag > {5'd0, angle_cap}) mag = {5'd0, angle_cap};
      hdr = {neg ? EastNibble : WestNibble, mag[11:8]};
      frame_q = {parity_byte(FramingByte), parity_byte(AddressByte),
                 parity_byte(GotoCmdByte), parity_byte(hdr), parity_byte(mag[7:0])};
      bits_rem = 6'(FrameBits);
      start_bit();
      r.accepted = 1'b1;
    end
    r.line     = line_lvl;
    r.busy_res = (bits_rem != 6'd0);
    if (it.req_type == ReqTick && bits_rem != 6'd0) advance_one_tick();
    return r;
  endfunction

  // ---------------- input driver ----------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        line_results_due.push_back(compute_line_result(in_data_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (items_to_send.size() != 0) begin
          in_data_i  <= items_to_send.pop_front();
          in_valid_i <= 1'b1;
          gap_left   <= pause_for(send_calm);
          if ($urandom_range(0, 23) == 0) send_calm <= !send_calm;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------- result monitor ----------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (line_results_due.size() == 0) begin
          log_mismatch($sformatf("unexpected result %b", out_data_o));
        end else begin
          want = line_results_due.pop_front();
          if (out_data_o.line !== want.line)
            log_mismatch($sformatf("line got %b want %b", out_data_o.line, want.line));
          if (out_data_o.busy_res !== want.busy_res)
            log_mismatch($sformatf("busy_res got %b want %b",
                                   out_data_o.busy_res, want.busy_res));
          if (out_data_o.accepted !== want.accepted)
            log_mismatch($sformatf("accepted got %b want %b",
                                   out_data_o.accepted, want.accepted));
        end
        rx_pause = pause_for(recv_calm);
        hold_left   <= rx_pause;
        out_stall_i <= (rx_pause != 0);
        if ($urandom_range(0, 23) == 0) recv_calm <= !recv_calm;
      end else if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= (hold_left > 1);
      end
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------- stimulus helpers ----------------

  task automatic reg_write(input reg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_HIGH_TIME:   tone_high      = val[7:0];
      REG_LOW_TIME:    tone_low       = val[7:0];
      REG_LONG_BURST:  zero_burst     = val[5:0];
      REG_SHORT_BURST: one_burst      = val[5:0];
      REG_LONG_GAP:    gap_after_one  = val[11:0];
      REG_SHORT_GAP:   gap_after_zero = val[11:0];
      REG_ANGLE_LIMIT: angle_cap      = val[11:0];
      default: ;
    endcase
  endtask

  task automatic set_timing(input logic [31:0] hi, input logic [31:0] lo,
                            input logic [31:0] zb, input logic [31:0] ob,
                            input logic [31:0] og, input logic [31:0] zg,
                            input logic [31:0] cap);
    reg_write(REG_HIGH_TIME, hi);
    reg_write(REG_LOW_TIME, lo);
    reg_write(REG_LONG_BURST, zb);
    reg_write(REG_SHORT_BURST, ob);
    reg_write(REG_LONG_GAP, og);
    reg_write(REG_SHORT_GAP, zg);
    reg_write(REG_ANGLE_LIMIT, cap);
  endtask

  function automatic void queue_item(input logic kind, input logic [15:0] ang);
    in_item_t it;
    it.req_type = kind;
    it.angle    = ang;
    items_to_send.push_back(it);
  endfunction

  function automatic void queue_ticks(input int n);
    for (int i = 0; i < n; i++) queue_item(ReqTick, 16'($urandom));
  endfunction

  // mostly ticks with occasional gotos, many of which land mid-frame
  function automatic void queue_random(input int n, input int goto_odds);
    logic [15:0] ang;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0:       ang = 16'($urandom_range(0, 4200));
        1:       ang = 16'h0000 - 16'($urandom_range(0, 4200));
        default: ang = 16'($urandom);
      endcase
      queue_item(($urandom_range(1, goto_odds) == 1) ? ReqGoto : ReqTick, ang);
    end
  endfunction

  // sender holds off until every expected result is back
  task automatic wait_idle();
    while (items_to_send.size() != 0 || in_valid_i || line_results_due.size() != 0)
      @(posedge clk_i);
  endtask

  // ---------------- test sequence ----------------

  initial begin
    tone_high      = HighTimeRst;
    tone_low       = LowTimeRst;
    zero_burst     = LongBurstRst;
    one_burst      = ShortBurstRst;
    gap_after_one  = LongGapRst;
    gap_after_zero = ShortGapRst;
    angle_cap      = AngleLimitRst;
    frame_q        = '0;
    bits_rem       = '0;
    in_silence     = 1'b0;
    cyc_rem        = '0;
    ticks_rem      = '0;
    line_lvl       = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset timing: idle ticks, a goto, a refused goto while busy
    queue_ticks(3);
    queue_item(ReqGoto, 16'd100);
    queue_item(ReqGoto, 16'h8000);
    queue_ticks(40);
    wait_idle();

    // shortest bits, zero gaps, widest limit; timing change lands mid-frame
    set_timing(1, 1, 1, 1, 0, 0, 4095);
    queue_ticks(130);
    queue_item(ReqGoto, 16'h8000);
    queue_ticks(90);
    wait_idle();

    // short bits with small gaps, reset limit
    set_timing(1, 1, 1, 1, 2, 2, 1200);
    queue_item(ReqGoto, 16'h0000);
    queue_random(50, 25);
    wait_idle();

    // zero limit, gap after ones only
    set_timing(1, 1, 2, 1, 1, 0, 0);
    queue_random(60, 20);
    wait_idle();

    // every count written as zero
    set_timing(0, 0, 0, 0, 0, 0, 2048);
    queue_random(30, 15);
    queue_ticks(10);
    wait_idle();

    // all settings at their top values
    set_timing(255, 255, 63, 63, 4095, 4095, 4095);
    queue_item(ReqGoto, 16'($urandom));
    queue_ticks(30);
    wait_idle();

    repeat (5) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/dgat_pkg.sv
rtl/dgat_cfg_regs.sv
rtl/dgat_frame_core.sv
rtl/dgat_out_buf.sv
rtl/diseqc_goto_angle_transmitter.sv
dv/tb_diseqc_goto_angle_transmitter.sv
